// File: rtl/pfa_pkg.sv
// Package for the paged frame allocator: field widths, status codes,
// request kinds and the result record. No dependencies.
package pfa_pkg;

    localparam int PID_W       = 8;
    localparam int PAGE_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int LAST_FRAME_W = 5;
    localparam int FREED_W     = 6;
    localparam int OWNER_W     = PID_W + 1;
    localparam int RES_DEPTH   = 32;
    localparam int RQ_AW       = 5;
    localparam int RQ_CW       = 6;

    localparam logic [OWNER_W-1:0] OWNER_FREE = 9'h100;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_DEALLOC = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FRAMES   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EVICTED     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_DEALLOCATED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_QUEUE_FULL  = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [PID_W-1:0]        evicted_id;
        logic [LAST_FRAME_W-1:0] last_frame;
        logic                    reloaded;
        logic [FREED_W-1:0]      freed_count;
        logic                    last;
    } pfa_res_t;

endpackage

// File: rtl/pfa_req_if.sv
// Request channel of the frame allocator: valid, ready and request fields.
// Depends on pfa_pkg.
interface pfa_req_if
    import pfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] page_count;

    modport source (output valid, kind, process_id, page_count, input ready);
    modport sink   (input valid, kind, process_id, page_count, output ready);
endinterface

// File: rtl/pfa_rsp_if.sv
// Result channel of the frame allocator: valid, ready and result fields.
// Depends on pfa_pkg.
interface pfa_rsp_if
    import pfa_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [PID_W-1:0]        evicted_id;
    logic [LAST_FRAME_W-1:0] last_frame;
    logic                    reloaded;
    logic [FREED_W-1:0]      freed_count;
    logic                    last;

    modport source (output valid, status, evicted_id, last_frame, reloaded, freed_count, last,
                    input ready);
    modport sink   (input valid, status, evicted_id, last_frame, reloaded, freed_count, last,
                    output ready);
endinterface

// File: rtl/pfa_out_stage.sv
// Output register of the frame allocator: holds one result beat until taken.
// Depends on pfa_pkg and pfa_rsp_if.
module pfa_out_stage
    import pfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  pfa_res_t push_res,
    output logic     space,
    pfa_rsp_if.source rsp
);
    logic     vld_reg;
    pfa_res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (push)
        begin
            vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_res;
        end
    end

    assign space           = !vld_reg || rsp.ready;
    assign rsp.valid       = vld_reg;
    assign rsp.status      = data_reg.status;
    assign rsp.evicted_id  = data_reg.evicted_id;
    assign rsp.last_frame  = data_reg.last_frame;
    assign rsp.reloaded    = data_reg.reloaded;
    assign rsp.freed_count = data_reg.freed_count;
    assign rsp.last        = data_reg.last;
endmodule

// File: rtl/paged_frame_allocator_fifo_swap.sv
// Top level of the paged frame allocator with FIFO swapping: sequencer and memories.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if and pfa_out_stage.
//
// Usage:
//   req carries one request beat (kind, process_id, page_count); rsp carries
//   the result beats, last set on the final one. A request is taken only when
//   the previous one has finished; evictions come first, one beat each.
//   A deallocate or each eviction scans the whole owner memory; an allocate
//   pops its frames from the free list one at a time, reading each frame and
//   then writing its owner, after any evictions. The next request waits for
//   the previous one, so the owner memory scan and the free-list read port
//   set how often requests are taken.
//   Reset: a clearing pass fills the free list and clears owners and swapped
//   bits; req.ready stays low meanwhile.
//   Stall: a result beat waits in the output register; the sequencer holds
//   while the register is full and rsp.ready is low.
module paged_frame_allocator_fifo_swap
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES    = 32,
    parameter int MAX_PROCESSES = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    pfa_req_if.sink   req,
    pfa_rsp_if.source rsp
);
    localparam int FW      = $clog2(NUM_FRAMES);
    localparam int FCW     = $clog2(NUM_FRAMES + 1);
    localparam int TW      = FW + 1;
    localparam int SW      = $clog2(MAX_PROCESSES);
    localparam int CLR_LEN = (NUM_FRAMES > MAX_PROCESSES) ? NUM_FRAMES : MAX_PROCESSES;
    localparam int CW      = $clog2(CLR_LEN + 1);
    localparam int PIDS    = 1 << PID_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_RQ_WT  = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_SW_WT  = 4'd5;
    localparam logic [3:0] S_POP_RD = 4'd6;
    localparam logic [3:0] S_POP_WT = 4'd7;
    localparam logic [3:0] S_PUSH   = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [FW-1:0]      ff_mem [NUM_FRAMES];
    logic [OWNER_W-1:0] ow_mem [NUM_FRAMES];
    logic [PID_W-1:0]   rq_mem [RES_DEPTH];
    logic               sw_mem [MAX_PROCESSES];

    logic [SW-1:0] mod_tbl [PIDS];

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic [FW-1:0]     fhead_reg, fhead_next;
    logic [FCW-1:0]    fcount_reg, fcount_next;
    logic [RQ_AW-1:0]  rhead_reg, rhead_next;
    logic [RQ_CW-1:0]  rcount_reg, rcount_next;
    logic [PID_W-1:0]  pid_reg, pid_next;
    logic [PAGE_W-1:0] need_reg, need_next;
    logic [PAGE_W-1:0] left_reg, left_next;
    logic [PID_W-1:0]  spid_reg, spid_next;
    logic [FCW-1:0]    scan_reg, scan_next;
    logic              evld_reg, evld_next;
    logic [FW-1:0]     eidx_reg, eidx_next;
    logic [FCW-1:0]    nfree_reg, nfree_next;
    pfa_res_t          res_reg, res_next;

    logic               ff_we, ow_we, rq_we, sw_we;
    logic [FW-1:0]      ff_waddr, ff_wdata, ff_raddr, ff_rdata;
    logic [FW-1:0]      ow_waddr, ow_raddr;
    logic [OWNER_W-1:0] ow_wdata, ow_rdata;
    logic [PID_W-1:0]   rq_rdata;
    logic [SW-1:0]      sw_waddr, sw_raddr;
    logic               sw_wdata, sw_rdata;

    logic [TW-1:0] tail_sum;
    logic [FW-1:0] tail;
    logic          short;
    logic          out_push, out_space;

    for (genvar g = 0; g < PIDS; g++)
    begin : g_mod
        assign mod_tbl[g] = SW'(g % MAX_PROCESSES);
    end

    assign tail_sum = TW'(fhead_reg) + TW'(fcount_reg);
    assign tail     = (tail_sum >= TW'(NUM_FRAMES)) ? FW'(tail_sum - TW'(NUM_FRAMES))
                                                    : FW'(tail_sum);
    assign short    = 7'(need_reg) > 7'(fcount_reg);

    always_ff @(posedge clk)
    begin
        if (ff_we)
        begin
            ff_mem[ff_waddr] <= ff_wdata;
        end
        ff_rdata <= ff_mem[ff_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ow_we)
        begin
            ow_mem[ow_waddr] <= ow_wdata;
        end
        ow_rdata <= ow_mem[ow_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rq_we)
        begin
            rq_mem[RQ_AW'(rhead_reg + RQ_AW'(rcount_reg))] <= pid_reg;
        end
        rq_rdata <= rq_mem[rhead_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sw_we)
        begin
            sw_mem[sw_waddr] <= sw_wdata;
        end
        sw_rdata <= sw_mem[sw_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        fhead_next  = fhead_reg;
        fcount_next = fcount_reg;
        rhead_next  = rhead_reg;
        rcount_next = rcount_reg;
        pid_next    = pid_reg;
        need_next   = need_reg;
        left_next   = left_reg;
        spid_next   = spid_reg;
        scan_next   = scan_reg;
        evld_next   = evld_reg;
        eidx_next   = eidx_reg;
        nfree_next  = nfree_reg;
        res_next    = res_reg;
        ff_we       = 1'b0;
        ff_waddr    = tail;
        ff_wdata    = eidx_reg;
        ff_raddr    = fhead_reg;
        ow_we       = 1'b0;
        ow_waddr    = eidx_reg;
        ow_wdata    = OWNER_FREE;
        ow_raddr    = scan_reg[FW-1:0];
        rq_we       = 1'b0;
        sw_we       = 1'b0;
        sw_waddr    = mod_tbl[pid_reg];
        sw_wdata    = 1'b0;
        sw_raddr    = mod_tbl[pid_reg];
        out_push    = 1'b0;
        req.ready   = 1'b0;

        unique case (state_reg)
            S_CLR:
            begin
                ff_waddr = clr_reg[FW-1:0];
                ff_wdata = clr_reg[FW-1:0];
                ow_waddr = clr_reg[FW-1:0];
                sw_waddr = clr_reg[SW-1:0];
                ff_we    = clr_reg < CW'(NUM_FRAMES);
                ow_we    = clr_reg < CW'(NUM_FRAMES);
                sw_we    = clr_reg < CW'(MAX_PROCESSES);
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CLR_LEN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    pid_next  = req.process_id;
                    need_next = req.page_count;
                    res_next  = '0;
                    if (req.kind == KIND_DEALLOC)
                    begin
                        res_next.status = STATUS_DEALLOCATED;
                        res_next.last   = 1'b1;
                        spid_next  = req.process_id;
                        scan_next  = '0;
                        evld_next  = 1'b0;
                        nfree_next = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                res_next = '0;
                if (short && rcount_reg != '0)
                begin
                    state_next = S_RQ_WT;
                end
                else if (short)
                begin
                    res_next.status = STATUS_NO_FRAMES;
                    res_next.last   = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (rcount_reg >= RQ_CW'(RES_DEPTH))
                begin
                    res_next.status = STATUS_QUEUE_FULL;
                    res_next.last   = 1'b1;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_SW_WT;
                end
            end
            S_RQ_WT:
            begin
                spid_next           = rq_rdata;
                rhead_next          = rhead_reg + 1'b1;
                rcount_next         = rcount_reg - 1'b1;
                sw_we               = 1'b1;
                sw_waddr            = mod_tbl[rq_rdata];
                sw_wdata            = 1'b1;
                res_next.status     = STATUS_EVICTED;
                res_next.evicted_id = rq_rdata;
                scan_next           = '0;
                evld_next           = 1'b0;
                nfree_next          = '0;
                state_next          = S_SCAN;
            end
            S_SCAN:
            begin
                if (evld_reg && ow_rdata == {1'b0, spid_reg})
                begin
                    ow_we      = 1'b1;
                    nfree_next = nfree_reg + 1'b1;
                    if (fcount_reg < FCW'(NUM_FRAMES))
                    begin
                        ff_we       = 1'b1;
                        fcount_next = fcount_reg + 1'b1;
                    end
                end
                if (scan_reg < FCW'(NUM_FRAMES))
                begin
                    evld_next = 1'b1;
                    eidx_next = scan_reg[FW-1:0];
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    evld_next = 1'b0;
                    if (!evld_reg)
                    begin
                        res_next.freed_count = FREED_W'(nfree_reg);
                        state_next           = S_EMIT;
                    end
                end
            end
            S_SW_WT:
            begin
                res_next.reloaded = sw_rdata;
                sw_we             = 1'b1;
                left_next         = need_reg;
                state_next        = S_POP_RD;
            end
            S_POP_RD:
            begin
                if (left_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    fhead_next  = (fhead_reg == FW'(NUM_FRAMES - 1)) ? '0 : fhead_reg + 1'b1;
                    fcount_next = fcount_reg - 1'b1;
                    left_next   = left_reg - 1'b1;
                    state_next  = S_POP_WT;
                end
            end
            S_POP_WT:
            begin
                ow_we               = 1'b1;
                ow_waddr            = ff_rdata;
                ow_wdata            = {1'b0, pid_reg};
                res_next.last_frame = LAST_FRAME_W'(ff_rdata);
                state_next          = S_POP_RD;
            end
            S_PUSH:
            begin
                rq_we           = 1'b1;
                rcount_next     = rcount_reg + 1'b1;
                res_next.status = STATUS_ALLOCATED;
                res_next.last   = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_space)
                begin
                    out_push   = 1'b1;
                    state_next = res_reg.last ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            fhead_reg  <= '0;
            fcount_reg <= FCW'(NUM_FRAMES);
            rhead_reg  <= '0;
            rcount_reg <= '0;
            scan_reg   <= '0;
            evld_reg   <= 1'b0;
            nfree_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            fhead_reg  <= fhead_next;
            fcount_reg <= fcount_next;
            rhead_reg  <= rhead_next;
            rcount_reg <= rcount_next;
            scan_reg   <= scan_next;
            evld_reg   <= evld_next;
            nfree_reg  <= nfree_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg  <= pid_next;
        need_reg <= need_next;
        left_reg <= left_next;
        spid_reg <= spid_next;
        eidx_reg <= eidx_next;
        res_reg  <= res_next;
    end

    pfa_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (out_push),
        .push_res (res_reg),
        .space    (out_space),
        .rsp      (rsp)
    );
endmodule

// File: rtl/pfa_check.sv
// Port-level checks for the paged frame allocator, bound to the top level.
// Depends on pfa_pkg.
module pfa_check
    import pfa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [FREED_W-1:0]  freed_count,
    input logic                last
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((status == STATUS_EVICTED) == !last))
        else $error("last flag does not match status");

    a_freed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != STATUS_EVICTED && status != STATUS_DEALLOCATED
        |-> freed_count == '0)
        else $error("freed count on a result that frees nothing");
endmodule

bind paged_frame_allocator_fifo_swap pfa_check u_pfa_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .freed_count (rsp.freed_count),
    .last        (rsp.last)
);

// File: dv/paged_frame_allocator_fifo_swap_test.sv
// Self-checking test of the paged frame allocator: drives allocate and deallocate
// requests, predicts every result beat with a behavioural model and compares them.
// Depends on pfa_pkg, pfa_req_if, pfa_rsp_if and paged_frame_allocator_fifo_swap.
`timescale 1ns / 1ps

module paged_frame_allocator_fifo_swap_test;
    import pfa_pkg::*;

    localparam int FRAMES = 32;
    localparam int PROCS  = 256;

    typedef struct packed {
        logic              kind;
        logic [PID_W-1:0]  pid;
        logic [PAGE_W-1:0] pages;
    } request_t;

    logic clk;
    logic rst_n;

    pfa_req_if req();
    pfa_rsp_if rsp();

    paged_frame_allocator_fifo_swap u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    request_t pending_reqs[$];
    pfa_res_t expected_beats[$];

    logic [4:0]         fifo_frames[FRAMES];
    int                 fifo_head;
    int                 fifo_count;
    logic [OWNER_W-1:0] owner_of[FRAMES];
    logic [PID_W-1:0]   resident_ids[RES_DEPTH];
    int                 res_head;
    int                 res_count;
    bit                 swapped[PROCS];

    int  errors;
    int  beats_seen;
    int  reqs_sent;
    int  evictions_seen;
    int  gap_left;
    bit  hold_send;
    bit  driver_idle;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic pfa_res_t make_beat(logic [STATUS_W-1:0] st, logic [PID_W-1:0] ev,
                                           logic [4:0] lf, logic rl, logic [5:0] fc,
                                           logic lst);
        pfa_res_t r;
        r.status = st;
        r.evicted_id = ev;
        r.last_frame = lf;
        r.reloaded = rl;
        r.freed_count = fc;
        r.last = lst;
        return r;
    endfunction

    function automatic void expect_beat(pfa_res_t b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic int release_owned(logic [PID_W-1:0] pid);
        int n;
        n = 0;
        for (int f = 0; f < FRAMES; f++)
        begin
            if (owner_of[f] == {1'b0, pid})
            begin
                owner_of[f] = OWNER_FREE;
                if (fifo_count < FRAMES)
                begin
                    fifo_frames[(fifo_head + fifo_count) % FRAMES] = f[4:0];
                    fifo_count++;
                end
                n++;
            end
        end
        return n;
    endfunction

    task automatic predict_allocation(request_t rq);
        int need;
        int n;
        logic [PID_W-1:0] victim;
        logic rl;
        logic [4:0] lf;
        need = rq.pages;
        rl = 1'b0;
        lf = '0;
        if (rq.kind == KIND_DEALLOC)
        begin
            n = release_owned(rq.pid);
            expect_beat(make_beat(STATUS_DEALLOCATED, '0, '0, 1'b0, n[5:0], 1'b1));
            return;
        end
        while (need > fifo_count && res_count > 0)
        begin
            victim = resident_ids[res_head];
            res_head = (res_head + 1) % RES_DEPTH;
            res_count--;
            n = release_owned(victim);
            swapped[victim] = 1'b1;
            expect_beat(make_beat(STATUS_EVICTED, victim, '0, 1'b0, n[5:0], 1'b0));
        end
        if (need > fifo_count)
        begin
            expect_beat(make_beat(STATUS_NO_FRAMES, '0, '0, 1'b0, '0, 1'b1));
            return;
        end
        if (res_count >= RES_DEPTH)
        begin
            expect_beat(make_beat(STATUS_QUEUE_FULL, '0, '0, 1'b0, '0, 1'b1));
            return;
        end
        if (swapped[rq.pid])
        begin
            swapped[rq.pid] = 1'b0;
            rl = 1'b1;
        end
        for (int i = 0; i < need; i++)
        begin
            lf = fifo_frames[fifo_head];
            fifo_head = (fifo_head + 1) % FRAMES;
            fifo_count--;
            owner_of[lf] = {1'b0, rq.pid};
        end
        resident_ids[(res_head + res_count) % RES_DEPTH] = rq.pid;
        res_count++;
        expect_beat(make_beat(STATUS_ALLOCATED, '0, lf, rl, '0, 1'b1));
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at beat %0d: %s got %0d expected %0d", beats_seen, what, got, want);
        errors++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(5, 40);
    endfunction

    task automatic add_req(logic k, int pid, int pages);
        request_t r;
        r.kind = k;
        r.pid = pid[PID_W-1:0];
        r.pages = pages[PAGE_W-1:0];
        pending_reqs = {pending_reqs, r};
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.kind <= 1'b0;
            req.process_id <= '0;
            req.page_count <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_allocation('{req.kind, req.process_id, req.page_count});
                reqs_sent <= reqs_sent + 1;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0 && !hold_send)
                begin
                    request_t r;
                    r = pending_reqs.pop_front();
                    req.valid <= 1'b1;
                    req.kind <= r.kind;
                    req.process_id <= r.pid;
                    req.page_count <= r.pages;
                    gap_left <= random_gap();
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                pfa_res_t w;
                beats_seen <= beats_seen + 1;
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unexpected beat, status", rsp.status, 0);
                end
                else
                begin
                    w = expected_beats.pop_front();
                    if (w.status == STATUS_EVICTED)
                        evictions_seen <= evictions_seen + 1;
                    if (rsp.status !== w.status)
                        report_mismatch("status", rsp.status, w.status);
                    if (rsp.evicted_id !== w.evicted_id)
                        report_mismatch("evicted_id", rsp.evicted_id, w.evicted_id);
                    if (rsp.last_frame !== w.last_frame)
                        report_mismatch("last_frame", rsp.last_frame, w.last_frame);
                    if (rsp.reloaded !== w.reloaded)
                        report_mismatch("reloaded", rsp.reloaded, w.reloaded);
                    if (rsp.freed_count !== w.freed_count)
                        report_mismatch("freed_count", rsp.freed_count, w.freed_count);
                    if (rsp.last !== w.last)
                        report_mismatch("last", rsp.last, w.last);
                end
            end
            if ($urandom_range(0, 9) < 7)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
        end
    end

    initial
    begin
        int pool[$];
        int mode;
        errors = 0;
        beats_seen = 0;
        reqs_sent = 0;
        evictions_seen = 0;
        hold_send = 1'b0;
        for (int i = 0; i < FRAMES; i++)
        begin
            fifo_frames[i] = i[4:0];
            owner_of[i] = OWNER_FREE;
        end
        for (int i = 0; i < RES_DEPTH; i++)
            resident_ids[i] = '0;
        for (int i = 0; i < PROCS; i++)
            swapped[i] = 1'b0;
        fifo_head = 0;
        fifo_count = FRAMES;
        res_head = 0;
        res_count = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero pages, oversize, reload, empty dealloc
        add_req(KIND_DEALLOC, 7, 1);
        add_req(KIND_ALLOC, 0, 0);
        add_req(KIND_ALLOC, 255, 32);
        add_req(KIND_ALLOC, 1, 1);
        add_req(KIND_ALLOC, 2, 63);
        add_req(KIND_ALLOC, 170, 20);
        add_req(KIND_ALLOC, 85, 12);
        add_req(KIND_ALLOC, 170, 16);
        add_req(KIND_DEALLOC, 85, 0);
        add_req(KIND_ALLOC, 170, 5);
        add_req(KIND_ALLOC, 170, 5);
        add_req(KIND_DEALLOC, 170, 42);
        add_req(KIND_ALLOC, 3, 31);
        add_req(KIND_DEALLOC, 255, 21);
        for (int i = 0; i < 33; i++)
            add_req(KIND_ALLOC, 100 + i, 0);
        add_req(KIND_ALLOC, 9, 32);

        while (pending_reqs.size() > 0 || req.valid)
            @(posedge clk);
        hold_send = 1'b1;
        while (expected_beats.size() > 0)
            @(posedge clk);
        hold_send = 1'b0;

        for (int i = 0; i < 6; i++)
            pool = {pool, int'($urandom_range(0, 255))};
        for (int n = 0; n < 82; n++)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
                add_req(KIND_ALLOC, pool[$urandom_range(0, 5)], $urandom_range(0, 12));
            else if (mode < 7)
                add_req(KIND_DEALLOC, pool[$urandom_range(0, 5)], $urandom_range(0, 63));
            else if (mode < 9)
                add_req(KIND_ALLOC, $urandom_range(0, 255), $urandom_range(0, 63));
            else
                add_req(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                        $urandom_range(0, 63));
            if (n == 41)
            begin
                while (pending_reqs.size() > 0 || req.valid)
                    @(posedge clk);
                hold_send = 1'b1;
                while (expected_beats.size() > 0)
                    @(posedge clk);
                hold_send = 1'b0;
            end
        end

        while (pending_reqs.size() > 0 || req.valid || expected_beats.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d requests sent, %0d result beats checked, %0d evictions seen",
                 reqs_sent, beats_seen, evictions_seen);
        if (errors == 0)
            $display("paged_frame_allocator_fifo_swap verification clean");
        else
            $display("paged_frame_allocator_fifo_swap verification failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("paged_frame_allocator_fifo_swap verification failed");
        $finish;
    end

endmodule
